>>> hw/rtl/hcmp_pkg.sv
// shared types and constants of the hop count search block
// no dependencies; used by hcmp_div and hop_count_by_matrix_power
package hcmp_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned CntW     = $clog2(MaxNodes + 1);
  localparam int unsigned PosW     = $clog2(MaxNodes * MaxNodes + 1);
  localparam int unsigned EntryW   = 32;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_SOURCE     = 2'd1,
    REG_DEST       = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic            start;
    logic [PosW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [PosW-1:0] quotient;
    logic [CntW-1:0] remainder;
  } div_rsp_t;

endpackage

>>> hw/rtl/hcmp_div.sv
// restoring divider, one quotient bit per cycle
// splits the linear load position into row and column; uses hcmp_pkg
module hcmp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcmp_pkg::div_req_t req_i,
  output hcmp_pkg::div_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(hcmp_pkg::PosW + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [StepW-1:0]            step_q;
  logic [hcmp_pkg::PosW-1:0]   quo_q;
  logic [hcmp_pkg::CntW-1:0]   rem_q;
  logic [hcmp_pkg::CntW-1:0]   div_q;
  logic [hcmp_pkg::CntW:0]     shifted;
  logic [hcmp_pkg::CntW:0]     diff;
  logic                        ge;

  assign shifted = {rem_q, quo_q[hcmp_pkg::PosW-1]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= StepW'(hcmp_pkg::PosW);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[hcmp_pkg::PosW-2:0], ge};
      rem_q <= ge ? diff[hcmp_pkg::CntW-1:0] : shifted[hcmp_pkg::CntW-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> hw/rtl/hop_count_by_matrix_power.sv
// top level: least hop count between two nodes by boolean matrix powers
// depends on hcmp_pkg and hcmp_div
//
// usage
//   input channel (in_valid_i / in_stall_o) carries one adjacency entry per
//   transaction in row-major order; entry_value_i > 0 is an edge. the
//   transaction with last_entry_i set starts the search. entries are taken
//   one per cycle while loading.
//   output channel (out_valid_o / out_stall_i) carries one result per search:
//   path_length_o (0 when no path) and path_found_o.
//   when source or destination is out of range the last entry sends the
//   search straight to its final state; else each hop sweeps the n matrix
//   rows (n nodes in use) through the single read port of the row memory,
//   one row per cycle.
//   writing node_count flushes the partial row and re-splits the load
//   position with a serial divider: input stalls until the divider is done.
//   the output register holds a result while out_stall_i is high; loading
//   of the next matrix goes on meanwhile, and a new search waits in its
//   final state until the output register is free.
//   reset: node_count 64, source 0, destination 0, load position zero; the
//   row memory is not cleared, so rows never loaded since reset are unknown.
//   apb port: node_count at 0x0, source_node at 0x4, destination_node at 0x8
module hop_count_by_matrix_power (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // apb configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hcmp_pkg::AddrW-1:0]         paddr,
  input  logic [hcmp_pkg::DataW-1:0]         pwdata,
  output logic [hcmp_pkg::DataW-1:0]         prdata,
  output logic                               pready,
  // entry stream
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [hcmp_pkg::EntryW-1:0] entry_value_i,
  input  logic                               last_entry_i,
  // result stream
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [hcmp_pkg::NodeW-1:0]         path_length_o,
  output logic                               path_found_o
);

  localparam int unsigned N  = hcmp_pkg::MaxNodes;
  localparam int unsigned NW = hcmp_pkg::NodeW;
  localparam int unsigned CW = hcmp_pkg::CntW;
  localparam int unsigned PW = hcmp_pkg::PosW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_SRC_RD,
    ST_SRC_CHK,
    ST_SWEEP,
    ST_HOP_END,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [CW-1:0] node_count_q;
  logic [NW-1:0] src_q;
  logic [NW-1:0] dst_q;

  // load side
  logic [CW-1:0] row_q;
  logic [NW-1:0] col_q;
  logic [PW-1:0] pos_q;
  logic [N-1:0]  buf_q;
  logic [N-1:0]  mask_q;

  // search side
  logic [N-1:0]  reach_q;
  logic [N-1:0]  acc_q;
  logic [NW-1:0] rd_l_q;
  logic          pend_q;
  logic [NW-1:0] hops_q;
  logic [NW-1:0] res_len_q;
  logic          res_found_q;
  logic [N-1:0]  rdata_q;

  // output register
  logic          out_valid_q;
  logic [NW-1:0] out_len_q;
  logic          out_found_q;

  // row memory: one 64-bit row of edge bits per node
  logic [N-1:0]  adj_mem [N];

  logic                 cfg_wr;
  hcmp_pkg::cfg_reg_e   cfg_idx;
  logic                 cfg_n_wr;
  logic [CW-1:0]        n_eff;
  logic [N-1:0]         col_mask;
  logic                 in_acc;
  logic                 edge_bit;
  logic                 store_en;
  logic                 row_done;
  logic [N-1:0]         buf_d;
  logic [N-1:0]         mask_d;
  logic                 mem_we;
  logic [NW-1:0]        mem_waddr;
  logic [N-1:0]         mem_wmask;
  logic [N-1:0]         mem_wdata;
  logic                 rd_en;
  logic [NW-1:0]        rd_addr;
  logic [N-1:0]         acc_next;
  logic [N-1:0]         src_reach;
  logic [N-1:0]         hop_reach;
  logic                 bad_nodes;
  logic                 out_free;
  hcmp_pkg::div_req_t   div_req;
  hcmp_pkg::div_rsp_t   div_rsp;

  // ---------------------------------------------------------------- apb
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = hcmp_pkg::cfg_reg_e'(paddr[3:2]);
  assign cfg_n_wr = cfg_wr && (cfg_idx == hcmp_pkg::REG_NODE_COUNT);

  always_comb begin
    case (cfg_idx)
      hcmp_pkg::REG_NODE_COUNT: prdata = hcmp_pkg::DataW'(node_count_q);
      hcmp_pkg::REG_SOURCE:     prdata = hcmp_pkg::DataW'(src_q);
      hcmp_pkg::REG_DEST:       prdata = hcmp_pkg::DataW'(dst_q);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CW'(N);
      src_q        <= '0;
      dst_q        <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hcmp_pkg::REG_NODE_COUNT: node_count_q <= pwdata[CW-1:0];
        hcmp_pkg::REG_SOURCE:     src_q        <= pwdata[NW-1:0];
        hcmp_pkg::REG_DEST:       dst_q        <= pwdata[NW-1:0];
        default: ;
      endcase
    end
  end

  // node count clamped to the supported range
  always_comb begin
    if (node_count_q < CW'(2)) begin
      n_eff = CW'(2);
    end else if (node_count_q > CW'(N)) begin
      n_eff = CW'(N);
    end else begin
      n_eff = node_count_q;
    end
  end

  // shifting by the full width wraps to all ones after the subtract
  assign col_mask  = (N'(1) << n_eff) - N'(1);
  assign bad_nodes = ({1'b0, src_q} >= n_eff) || ({1'b0, dst_q} >= n_eff);

  // ---------------------------------------------------------------- load
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign edge_bit   = (entry_value_i > 0);
  assign store_en   = (row_q < n_eff);
  assign row_done   = store_en && ({1'b0, col_q} == n_eff - CW'(1));

  always_comb begin
    buf_d  = buf_q;
    mask_d = mask_q;
    if (store_en) begin
      buf_d[col_q]  = edge_bit;
      mask_d[col_q] = 1'b1;
    end
  end

  // a row goes to memory when complete, on the last entry, or before a
  // node count change re-splits the position
  always_comb begin
    mem_waddr = row_q[NW-1:0];
    if (in_acc) begin
      mem_we    = row_done || (last_entry_i && (|mask_d));
      mem_wmask = mask_d;
      mem_wdata = buf_d;
    end else begin
      mem_we    = cfg_n_wr && (|mask_q);
      mem_wmask = mask_q;
      mem_wdata = buf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < N; b++) begin
        if (mem_wmask[b]) begin
          adj_mem[mem_waddr][b] <= mem_wdata[b];
        end
      end
    end
  end

  assign rd_en   = (state_q == ST_SRC_RD) || (state_q == ST_SWEEP);
  assign rd_addr = (state_q == ST_SRC_RD) ? src_q : rd_l_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= adj_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- divider
  assign div_req.start    = (state_q == ST_DIV_GO);
  assign div_req.dividend = pos_q;
  assign div_req.divisor  = n_eff;

  hcmp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- search
  assign acc_next  = acc_q | ((pend_q) ? rdata_q : '0);
  assign src_reach = rdata_q & col_mask;
  assign hop_reach = acc_next & col_mask;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      pos_q       <= '0;
      mask_q      <= '0;
      pend_q      <= 1'b0;
      rd_l_q      <= '0;
      hops_q      <= '0;
      res_len_q   <= '0;
      res_found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      pend_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            buf_q <= buf_d;
            if (last_entry_i) begin
              row_q  <= '0;
              col_q  <= '0;
              pos_q  <= '0;
              mask_q <= '0;
              if (bad_nodes) begin
                res_len_q   <= '0;
                res_found_q <= 1'b0;
                state_q     <= ST_DONE;
              end else begin
                state_q <= ST_SRC_RD;
              end
            end else begin
              if (store_en) begin
                pos_q <= pos_q + PW'(1);
              end
              if (row_done) begin
                row_q  <= row_q + CW'(1);
                col_q  <= '0;
                mask_q <= '0;
              end else begin
                mask_q <= mask_d;
                if (store_en) begin
                  col_q <= col_q + NW'(1);
                end
              end
            end
          end
        end
        ST_DIV_GO: begin
          state_q <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          if (div_rsp.done) begin
            // rows past the matrix are ignored, so saturate at n
            if (div_rsp.quotient >= PW'(n_eff)) begin
              row_q <= n_eff;
            end else begin
              row_q <= div_rsp.quotient[CW-1:0];
            end
            col_q   <= div_rsp.remainder[NW-1:0];
            state_q <= ST_IDLE;
          end
        end
        ST_SRC_RD: begin
          state_q <= ST_SRC_CHK;
        end
        ST_SRC_CHK: begin
          reach_q <= src_reach;
          if (src_reach[dst_q]) begin
            res_len_q   <= NW'(1);
            res_found_q <= 1'b1;
            state_q     <= ST_DONE;
          end else if (n_eff <= CW'(2)) begin
            res_len_q   <= '0;
            res_found_q <= 1'b0;
            state_q     <= ST_DONE;
          end else begin
            hops_q  <= NW'(2);
            acc_q   <= '0;
            rd_l_q  <= '0;
            state_q <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          // issue one row read per cycle, fold in the row read last cycle
          acc_q  <= acc_next;
          pend_q <= reach_q[rd_l_q];
          if ({1'b0, rd_l_q} == n_eff - CW'(1)) begin
            state_q <= ST_HOP_END;
          end else begin
            rd_l_q <= rd_l_q + NW'(1);
          end
        end
        ST_HOP_END: begin
          reach_q <= hop_reach;
          if (hop_reach[dst_q]) begin
            res_len_q   <= hops_q;
            res_found_q <= 1'b1;
            state_q     <= ST_DONE;
          end else if (({1'b0, hops_q} + CW'(1)) < n_eff) begin
            hops_q  <= hops_q + NW'(1);
            acc_q   <= '0;
            rd_l_q  <= '0;
            state_q <= ST_SWEEP;
          end else begin
            res_len_q   <= '0;
            res_found_q <= 1'b0;
            state_q     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_len_q   <= res_len_q;
            out_found_q <= res_found_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // node count change: partial row already flushed, re-split position
      if (cfg_n_wr) begin
        mask_q  <= '0;
        state_q <= ST_DIV_GO;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign path_length_o = out_len_q;
  assign path_found_o  = out_found_q;

`ifndef SYNTH
  // loading and searching never touch the row memory in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_we && rd_en))
    else $error("row memory written during a search read");

  // a new result only leaves the final search state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result presented outside the done state");

  // no path always reports a zero hop count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !path_found_o) |-> (path_length_o == '0))
    else $error("nonzero hop count without a path");

  // the row sweep stays inside the nodes in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> ({1'b0, rd_l_q} < n_eff))
    else $error("row sweep ran past the node count");
`endif

endmodule

>>> tb/testbench.sv
// self-checking testbench for the hop count search block hop_count_by_matrix_power
// depends on hcmp_pkg and the block's rtl; predicts every result on its own and
// compares it with the result channel

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcmp_pkg::*;

  // cycles let pass before a register write, once all results are in
  localparam int unsigned QuietCycles = 24;
  // cycles watched after the last result for anything spurious
  localparam int unsigned TailCycles  = 200;
  localparam int unsigned ReportLimit = 10;

  // one result transaction as the block reports it
  typedef struct packed {
    logic [NodeW-1:0] path_length;
    logic             path_found;
  } hop_result_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     psel          = 1'b0;
  logic                     penable       = 1'b0;
  logic                     pwrite        = 1'b0;
  logic [AddrW-1:0]         paddr         = '0;
  logic [DataW-1:0]         pwdata        = '0;
  logic [DataW-1:0]         prdata;
  logic                     pready;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic signed [EntryW-1:0] entry_value_i = '0;
  logic                     last_entry_i  = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic [NodeW-1:0]         path_length_o;
  logic                     path_found_o;

  hop_count_by_matrix_power u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .entry_value_i (entry_value_i),
    .last_entry_i  (last_entry_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .path_length_o (path_length_o),
    .path_found_o  (path_found_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow of the block: edge matrix, load position and register values
  // ---------------------------------------------------------------------------
  logic [MaxNodes-1:0] edge_rows [MaxNodes] = '{default: '0};
  int unsigned         load_pos  = 0;
  logic [6:0]          cfg_nodes = 7'd64;
  logic [5:0]          cfg_src   = '0;
  logic [5:0]          cfg_dst   = '0;

  // results still owed by the block, oldest first
  hop_result_t pending_hops [$];

  int unsigned mismatch_count = 0;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // long receiver hold-off, requested by bumping the ticket
  int unsigned hold_len    = 0;
  int unsigned hold_ticket = 0;

  function automatic void note_mismatch(string what, longint unsigned want,
                                        longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  // out-of-range node counts are pulled into 2..MaxNodes
  function automatic int unsigned clamp_nodes(logic [6:0] raw);
    if (raw < 2) return 2;
    if (raw > MaxNodes) return MaxNodes;
    return raw;
  endfunction

  // least walk length from source to destination, 0 when none below n hops
  function automatic int unsigned hop_search(int unsigned n);
    logic [MaxNodes-1:0] mask;
    logic [MaxNodes-1:0] reach;
    logic [MaxNodes-1:0] widened;
    mask = '0;
    for (int unsigned l = 0; l < n; l++) mask[l] = 1'b1;
    // an endpoint outside the graph never has a path
    if (cfg_src >= n || cfg_dst >= n) return 0;
    reach = edge_rows[cfg_src] & mask;
    if (reach[cfg_dst]) return 1;
    for (int unsigned hops = 2; hops < n; hops++) begin
      // boolean product of the reach row with the matrix
      widened = '0;
      for (int unsigned l = 0; l < n; l++) begin
        if (reach[l]) widened |= edge_rows[l];
      end
      reach = widened & mask;
      if (reach[cfg_dst]) return hops;
    end
    return 0;
  endfunction

  // update the shadow with one accepted entry transaction
  function automatic void absorb_entry(logic signed [EntryW-1:0] value, logic last);
    int unsigned n;
    int unsigned hops;
    hop_result_t expected;
    n = clamp_nodes(cfg_nodes);
    // entries past a full matrix are dropped, placement follows current n
    if (load_pos < n * n) begin
      edge_rows[load_pos / n][load_pos % n] = (value > 0);
      load_pos++;
    end
    if (last) begin
      load_pos = 0;
      hops = hop_search(n);
      expected.path_length = hops[NodeW-1:0];
      expected.path_found  = (hops != 0);
      pending_hops.push_back(expected);
    end
  endfunction

  // random entry value, an edge when positive; extremes come up often
  function automatic logic signed [EntryW-1:0] make_entry(logic is_edge);
    logic [EntryW-1:0] v;
    case ($urandom_range(7))
      0: v = is_edge ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: v = is_edge ? 32'h0000_0001 : 32'hFFFF_FFFF;
      default: begin
        if (is_edge) begin
          v = {1'b0, 31'($urandom)};
          if (v == '0) v = 32'h0000_0001;
        end else if ($urandom_range(1) == 0) begin
          v = '0;
        end else begin
          v = {1'b1, 31'($urandom)};
        end
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall generator and checker
  // ---------------------------------------------------------------------------
  initial begin : result_stall_gen
    int unsigned hold_left;
    int unsigned seen_ticket;
    hold_left   = 0;
    seen_ticket = 0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != seen_ticket) begin
        seen_ticket = hold_ticket;
        hold_left   = hold_len;
      end
      if (hold_left != 0) begin
        // long hold-off so the block backs up into its input
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // every result transaction is matched against the oldest expectation
  always @(posedge clk_i) begin : result_check
    hop_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hops.size() == 0) begin
        note_mismatch("unexpected result", 0, {path_length_o, path_found_o});
      end else begin
        want = pending_hops.pop_front();
        if (path_length_o !== want.path_length) begin
          note_mismatch("path_length", want.path_length, path_length_o);
        end
        if (path_found_o !== want.path_found) begin
          note_mismatch("path_found", want.path_found, path_found_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------
  task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
    send_idle_pct  <= sender_pct;
    recv_stall_pct <= receiver_pct;
  endtask

  // offer one entry transaction, with a random gap first, until it is taken
  task automatic offer_entry(logic signed [EntryW-1:0] value, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    entry_value_i <= value;
    last_entry_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    absorb_entry(value, last);
  endtask

  // count entries with random edges, last_entry on the final one
  task automatic send_load(int unsigned count, int unsigned density_pct);
    for (int unsigned i = 0; i < count; i++) begin
      offer_entry(make_entry($urandom_range(99) < density_pct), i == count - 1);
    end
  endtask

  // wait until every result is in, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_hops.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  // one apb transfer; the bus is left selected so transfers can run back to back
  task automatic apb_access(cfg_reg_e idx, logic is_write, logic [DataW-1:0] wdata,
                            output logic [DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  task automatic read_check(cfg_reg_e idx, logic [DataW-1:0] want);
    logic [DataW-1:0] got;
    apb_access(idx, 1'b0, '0, got);
    if (got !== want) note_mismatch(idx.name(), want, got);
  endtask

  // write all three registers with junk in the unused bits, read each back
  task automatic configure(logic [6:0] nodes, logic [5:0] src, logic [5:0] dst);
    logic [DataW-1:0] wdata;
    logic [DataW-1:0] unused;
    wdata = $urandom;
    wdata[6:0] = nodes;
    apb_access(REG_NODE_COUNT, 1'b1, wdata, unused);
    cfg_nodes = nodes;
    read_check(REG_NODE_COUNT, DataW'(nodes));
    wdata = $urandom;
    wdata[5:0] = src;
    apb_access(REG_SOURCE, 1'b1, wdata, unused);
    cfg_src = src;
    read_check(REG_SOURCE, DataW'(src));
    wdata = $urandom;
    wdata[5:0] = dst;
    apb_access(REG_DEST, 1'b1, wdata, unused);
    cfg_dst = dst;
    read_check(REG_DEST, DataW'(dst));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    read_check(REG_NODE_COUNT, DataW'(64));
    read_check(REG_SOURCE, '0);
    read_check(REG_DEST, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // full 64-node ring at reset settings: the way back to node 0 is 64 hops,
  // one too many, so the search runs its longest and finds nothing; then the
  // far end of the ring is 63 hops away, the largest length reported.
  // this also writes every matrix entry, so later short loads are safe
  task automatic test_full_size_ring();
    int unsigned r;
    int unsigned c;
    for (r = 0; r < MaxNodes; r++) begin
      for (c = 0; c < MaxNodes; c++) begin
        offer_entry(make_entry(c == (r + 1) % MaxNodes),
                    r == MaxNodes - 1 && c == MaxNodes - 1);
      end
    end
    wait_idle();
    // short load: only entry (0,0) is replaced, and with no edge
    configure(7'd64, 6'd0, 6'd63);
    offer_entry(make_entry(1'b0), 1'b1);
    wait_idle();
  endtask

  // node counts below 2 act as 2, above the maximum act as the maximum
  task automatic test_node_count_clamp();
    configure(7'd0, 6'd1, 6'd0);
    offer_entry(make_entry(1'b0), 1'b0);
    offer_entry(make_entry(1'b0), 1'b0);
    offer_entry(make_entry(1'b1), 1'b0);
    offer_entry(make_entry(1'b0), 1'b1);
    wait_idle();
    configure(7'd1, 6'd0, 6'd1);
    offer_entry(make_entry(1'b1), 1'b1);
    wait_idle();
    configure(7'd127, 6'd0, 6'd63);
    offer_entry(make_entry(1'b1), 1'b1);
    wait_idle();
  endtask

  // source or destination at or past the node count: no path
  task automatic test_endpoints_out_of_range();
    configure(7'd4, 6'd5, 6'd0);
    offer_entry(make_entry(1'b1), 1'b1);
    wait_idle();
    configure(7'd4, 6'd0, 6'd4);
    offer_entry(make_entry(1'b1), 1'b1);
    wait_idle();
    configure(7'd4, 6'd63, 6'd63);
    offer_entry(make_entry(1'b1), 1'b1);
    wait_idle();
  endtask

  // sign and size extremes of the entry value
  task automatic test_entry_extremes();
    configure(7'd2, 6'd0, 6'd1);
    offer_entry(32'sh7FFF_FFFF, 1'b0);
    offer_entry(32'sh8000_0000, 1'b0);
    offer_entry(32'sh0000_0001, 1'b0);
    offer_entry(32'shFFFF_FFFF, 1'b1);
    wait_idle();
  endtask

  // a full matrix load, then a short load that replaces its first entries
  task automatic test_excess_entries();
    configure(7'd2, 6'd1, 6'd0);
    send_load(4, 30);
    offer_entry(make_entry(1'b1), 1'b0);
    offer_entry(make_entry(1'b1), 1'b0);
    offer_entry(make_entry(1'b1), 1'b1);
    wait_idle();
  endtask

  // node count rewritten with a load half done: the rest is placed by the new count
  task automatic test_node_count_change_mid_load();
    configure(7'd2, 6'd0, 6'd3);
    offer_entry(make_entry(1'b1), 1'b0);
    offer_entry(make_entry(1'b1), 1'b0);
    wait_idle();
    configure(7'd4, 6'd0, 6'd3);
    send_load(14, 40);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while matrices keep coming
  task automatic test_output_backpressure();
    configure(7'd3, 6'd0, 6'd2);
    hold_len    <= 1500;
    hold_ticket <= hold_ticket + 1;
    repeat (8) send_load(9, 30);
    wait_idle();
  endtask

  // random settings, each followed by a few loads, mostly complete matrices
  task automatic run_random_phase(int unsigned entry_goal);
    int unsigned taken;
    int unsigned n;
    int unsigned count;
    int unsigned pick;
    int unsigned density;
    int unsigned short_max;
    logic [6:0]  n_raw;
    logic [5:0]  src;
    logic [5:0]  dst;
    taken = 0;
    while (taken < entry_goal) begin
      pick = $urandom_range(99);
      if (pick < 70) n_raw = 7'($urandom_range(6, 2));
      else if (pick < 90) n_raw = 7'($urandom_range(12, 7));
      else if (pick < 96) n_raw = 7'($urandom_range(20, 13));
      else if (pick < 98) n_raw = 7'($urandom_range(1, 0));
      else n_raw = 7'($urandom_range(127, 64));
      n = clamp_nodes(n_raw);
      if ($urandom_range(99) < 88) begin
        src = 6'($urandom_range(n - 1));
        dst = 6'($urandom_range(n - 1));
      end else begin
        src = 6'($urandom);
        dst = 6'($urandom);
      end
      configure(n_raw, src, dst);
      short_max = (n * n - 1 < 20) ? n * n - 1 : 20;
      repeat ($urandom_range(4, 1)) begin
        case ($urandom_range(3))
          0: density = 5;
          1: density = 15;
          2: density = 30;
          default: density = 60;
        endcase
        pick = $urandom_range(99);
        // full-size matrices only as short loads, the whole matrix is already set
        if (n == MaxNodes || (pick >= 88 && pick < 96)) begin
          count = $urandom_range(short_max, 1);
        end else if (pick >= 96) begin
          count = n * n + $urandom_range(5, 1);
        end else begin
          count = n * n;
        end
        send_load(count, density);
        taken += (count < n * n) ? count : n * n;
      end
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(16, 75);
    test_reset_values();
    test_full_size_ring();
    test_node_count_clamp();
    test_endpoints_out_of_range();
    test_entry_extremes();
    test_excess_entries();
    test_node_count_change_mid_load();
    test_output_backpressure();

    run_random_phase(600);
    set_idling(75, 16);
    run_random_phase(600);
    set_idling(0, 0);
    run_random_phase(600);

    // drain, then watch a while for stray results
    in_valid_i <= 1'b0;
    while (pending_hops.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_hops.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, far past the slowest correct run
  initial begin
    #(10ms);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/hcmp_pkg.sv
hw/rtl/hcmp_div.sv
hw/rtl/hop_count_by_matrix_power.sv
tb/testbench.sv
